@@ rtl/frb_pkg.sv @@
// Shared types, constants and helpers of the FEC block reorder ring.
package frb_pkg;

    localparam int DEFAULT_RING_DEPTH    = 16;
    localparam int DEFAULT_MAX_FRAGMENTS = 32;

    localparam int BLOCK_W    = 56;
    localparam int FRAG_IDX_W = 8;
    localparam int CFG_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int MASK_W     = 32;
    localparam int SLOT_OUT_W = 4;
    localparam int CNT_W      = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_DATA_FRAGMENTS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_FRAGMENTS = 2'd1;

    localparam logic [CFG_W-1:0] RESET_DATA_FRAGMENTS  = 6'd8;
    localparam logic [CFG_W-1:0] RESET_TOTAL_FRAGMENTS = 6'd12;

    localparam logic KIND_DISP    = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        DISP_ACCEPTED  = 2'd0,
        DISP_DUPLICATE = 2'd1,
        DISP_STALE     = 2'd2,
        DISP_INVALID   = 2'd3
    } disp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_NEW,
        S_ALLOC,
        S_DUP,
        S_UPDATE,
        S_RUN,
        S_RUNEND,
        S_KCHK,
        S_FLUSH,
        S_POP,
        S_FULLREL,
        S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        EM_DISP_ZERO,
        EM_DISP_IDX,
        EM_DISP_NEW,
        EM_FLUSH,
        EM_RUN,
        EM_FULL
    } emit_src_t;

    typedef enum logic [1:0] {
        RD_PTR,
        RD_FRONT,
        RD_IDX
    } rd_sel_t;

    typedef struct packed {
        logic      in_ready;
        logic      search_init;
        logic      search_step;
        logic      search_hit;
        logic      new_init;
        logic      alloc_step;
        logic      map_update;
        logic      run_step;
        logic      front_pop;
        logic      pop_init;
        logic      pop_step;
        logic      set_ns_k;
        logic      emit;
        emit_src_t emit_src;
        disp_t     disp;
        logic      finish;
        rd_sel_t   rd_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic f_invalid;
        logic search_end;
        logic match;
        logic stale;
        logic alloc_end;
        logic full;
        logic dup;
        logic at_front;
        logic run_bit;
        logic ns_ge_k;
        logic k_complete;
        logic front_is_idx;
        logic pop_end;
        logic emit_ok;
        logic mask_nz;
        logic finish_ok;
    } ctrl_stat_t;

    typedef struct packed {
        logic                   kind;
        disp_t                  disposition;
        logic [SLOT_OUT_W-1:0]  slot;
        logic [BLOCK_W-1:0]     released_block;
        logic [MASK_W-1:0]      release_mask;
        logic                   needs_recovery;
        logic [CNT_W-1:0]       recovered_count;
        logic                   last;
    } result_item_t;

    // Mask of bits 0 .. x-1, all ones for x of 32 or more.
    function automatic logic [MASK_W-1:0] lo_mask(input logic [CNT_W-1:0] x);
        logic [MASK_W-1:0] m;
        if (x >= CNT_W'(MASK_W)) begin
            m = '1;
        end else begin
            m = (MASK_W'(1) << x[4:0]) - MASK_W'(1);
        end
        return m;
    endfunction

endpackage

@@ rtl/frb_if.sv @@
// Channel interfaces of the FEC block reorder ring.
interface frb_frag_if import frb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [BLOCK_W-1:0]    block_number;
    logic [FRAG_IDX_W-1:0] fragment_index;

    modport source (output valid, block_number, fragment_index, input ready);
    modport sink (input valid, block_number, fragment_index, output ready);
endinterface

interface frb_result_if import frb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [1:0]            disposition;
    logic [SLOT_OUT_W-1:0] slot;
    logic [BLOCK_W-1:0]    released_block;
    logic [MASK_W-1:0]     release_mask;
    logic                  needs_recovery;
    logic [CNT_W-1:0]      recovered_count;
    logic                  last;

    modport source (output valid, kind, disposition, slot, released_block, release_mask,
                    needs_recovery, recovered_count, last, input ready);
    modport sink (input valid, kind, disposition, slot, released_block, release_mask,
                  needs_recovery, recovered_count, last, output ready);
endinterface

interface frb_cfg_if import frb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/frb_ctrl.sv @@
// Sequencing state machine of the FEC block reorder ring.
module frb_ctrl import frb_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_stat_t stat,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_IDX;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.f_invalid)
                begin
                    if (stat.emit_ok)
                    begin
                        cmd.emit     = 1'b1;
                        cmd.emit_src = EM_DISP_ZERO;
                        cmd.disp     = DISP_INVALID;
                        state_next   = S_FINISH;
                    end
                end
                else
                begin
                    cmd.search_init = 1'b1;
                    state_next      = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                cmd.rd_sel = RD_PTR;
                if (stat.search_end)
                begin
                    state_next = S_NEW;
                end
                else if (stat.match)
                begin
                    cmd.search_hit = 1'b1;
                    state_next     = S_DUP;
                end
                else
                begin
                    cmd.search_step = 1'b1;
                end
            end
            S_NEW:
            begin
                if (stat.emit_ok)
                begin
                    cmd.emit = 1'b1;
                    if (stat.stale)
                    begin
                        cmd.emit_src = EM_DISP_ZERO;
                        cmd.disp     = DISP_STALE;
                        state_next   = S_FINISH;
                    end
                    else
                    begin
                        cmd.new_init = 1'b1;
                        cmd.emit_src = EM_DISP_NEW;
                        cmd.disp     = DISP_ACCEPTED;
                        state_next   = S_ALLOC;
                    end
                end
            end
            S_ALLOC:
            begin
                cmd.rd_sel = RD_FRONT;
                if (stat.alloc_end)
                begin
                    state_next = S_UPDATE;
                end
                else if (stat.full)
                begin
                    if (stat.emit_ok)
                    begin
                        cmd.emit       = 1'b1;
                        cmd.emit_src   = EM_FLUSH;
                        cmd.alloc_step = 1'b1;
                    end
                end
                else
                begin
                    cmd.alloc_step = 1'b1;
                end
            end
            S_DUP:
            begin
                if (stat.emit_ok)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = EM_DISP_IDX;
                    if (stat.dup)
                    begin
                        cmd.disp   = DISP_DUPLICATE;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.disp   = DISP_ACCEPTED;
                        state_next = S_UPDATE;
                    end
                end
            end
            S_UPDATE:
            begin
                cmd.map_update = 1'b1;
                state_next     = stat.at_front ? S_RUN : S_KCHK;
            end
            S_RUN:
            begin
                if (stat.run_bit)
                begin
                    cmd.run_step = 1'b1;
                end
                else
                begin
                    state_next = S_RUNEND;
                end
            end
            S_RUNEND:
            begin
                if (!stat.mask_nz || stat.emit_ok)
                begin
                    cmd.emit     = stat.mask_nz;
                    cmd.emit_src = EM_RUN;
                    if (stat.ns_ge_k)
                    begin
                        cmd.front_pop = 1'b1;
                        state_next    = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_KCHK;
                    end
                end
            end
            S_KCHK:
            begin
                state_next = stat.k_complete ? S_FLUSH : S_FINISH;
            end
            S_FLUSH:
            begin
                cmd.rd_sel = RD_FRONT;
                if (!stat.front_is_idx)
                begin
                    if (stat.emit_ok)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_src  = EM_FLUSH;
                        cmd.front_pop = 1'b1;
                    end
                end
                else
                begin
                    cmd.pop_init = 1'b1;
                    state_next   = S_POP;
                end
            end
            S_POP:
            begin
                cmd.pop_step = 1'b1;
                if (stat.pop_end)
                begin
                    state_next = S_FULLREL;
                end
            end
            S_FULLREL:
            begin
                if (stat.emit_ok)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_src  = EM_FULL;
                    cmd.set_ns_k  = 1'b1;
                    cmd.front_pop = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.finish_ok)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/frb_datapath.sv @@
// Ring storage, pointers, item buffers and configuration of the reorder ring.
module frb_datapath import frb_pkg::*; #(
    parameter int RING_DEPTH    = DEFAULT_RING_DEPTH,
    parameter int MAX_FRAGMENTS = DEFAULT_MAX_FRAGMENTS
) (
    input  logic      clk,
    input  logic      rst_n,
    frb_frag_if.sink     frag,
    frb_result_if.source result,
    frb_cfg_if.sink      cfg,
    input  ctrl_cmd_t  cmd,
    output ctrl_stat_t stat
);

    localparam int IW       = $clog2(RING_DEPTH);
    localparam int UW       = $clog2(RING_DEPTH + 1);
    localparam int FRAG_CAP = (MAX_FRAGMENTS < MASK_W) ? MAX_FRAGMENTS : MASK_W;

    // Ring storage; every slot is written on allocation before it is searched.
    logic [BLOCK_W-1:0] blk_mem [RING_DEPTH];
    logic [MASK_W-1:0]  map_mem [RING_DEPTH];
    logic [CNT_W-1:0]   cnt_mem [RING_DEPTH];
    logic [CNT_W-1:0]   ns_mem  [RING_DEPTH];

    logic [CFG_W-1:0]      k_cfg_reg;
    logic [CFG_W-1:0]      n_cfg_reg;
    logic [BLOCK_W-1:0]    b_reg;
    logic [FRAG_IDX_W-1:0] f_reg;
    logic [CNT_W-1:0]      k_reg;
    logic [CNT_W-1:0]      nf_reg;
    logic [IW-1:0]         ptr_reg;
    logic [UW-1:0]         rem_reg;
    logic [IW-1:0]         idx_reg;
    logic [IW-1:0]         front_reg;
    logic [UW-1:0]         used_reg;
    logic [BLOCK_W-1:0]    newest_reg;
    logic                  newest_valid_reg;
    logic [BLOCK_W-1:0]    alloc_blk_reg;
    logic [MASK_W-1:0]     mask_reg;
    logic [MASK_W-1:0]     want_reg;
    logic [MASK_W-1:0]     miss_reg;
    logic [CNT_W-1:0]      pop_cnt_reg;
    logic [1:0]            pop_idx_reg;
    result_item_t          pend_reg;
    logic                  pend_valid_reg;
    result_item_t          out_reg;
    logic                  out_valid_reg;

    logic [CNT_W-1:0]   nf_eff;
    logic [CNT_W-1:0]   k_eff;
    logic [IW-1:0]      tail;
    logic [IW-1:0]      rd_addr;
    logic [IW-1:0]      wr_addr;
    logic [BLOCK_W-1:0] rd_blk;
    logic [MASK_W-1:0]  rd_map;
    logic [CNT_W-1:0]   rd_cnt;
    logic [CNT_W-1:0]   rd_ns;
    logic [BLOCK_W-1:0] diff;
    logic [UW-1:0]      nb;
    logic [IW-1:0]      new_idx;
    logic [MASK_W-1:0]  range_mask;
    logic               latch;
    logic               out_free;
    result_item_t       new_item;
    result_item_t       out_load;

    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [UW-1:0] b);
        logic [IW:0] s;
        s = {1'b0, a} + (IW + 1)'(b);
        if (s >= (IW + 1)'(RING_DEPTH))
        begin
            s = s - (IW + 1)'(RING_DEPTH);
        end
        return s[IW-1:0];
    endfunction

    // Effective N and K from the raw register values.
    always_comb
    begin
        nf_eff = n_cfg_reg;
        if (nf_eff == '0)
        begin
            nf_eff = CNT_W'(1);
        end
        if (nf_eff > CNT_W'(FRAG_CAP))
        begin
            nf_eff = CNT_W'(FRAG_CAP);
        end
        k_eff = k_cfg_reg;
        if (k_eff == '0)
        begin
            k_eff = CNT_W'(1);
        end
        if (k_eff > nf_eff)
        begin
            k_eff = nf_eff;
        end
    end

    assign tail = wrap_add(front_reg, used_reg);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_PTR:   rd_addr = ptr_reg;
            RD_FRONT: rd_addr = front_reg;
            default:  rd_addr = idx_reg;
        endcase
    end

    assign rd_blk = blk_mem[rd_addr];
    assign rd_map = map_mem[rd_addr];
    assign rd_cnt = cnt_mem[rd_addr];
    assign rd_ns  = ns_mem[rd_addr];
    assign wr_addr = cmd.alloc_step ? tail : idx_reg;

    // Number of slots to open for a newer block, at most the ring depth.
    always_comb
    begin
        diff = b_reg - newest_reg;
        if (!newest_valid_reg)
        begin
            nb = UW'(1);
        end
        else if (diff > BLOCK_W'(RING_DEPTH))
        begin
            nb = UW'(RING_DEPTH);
        end
        else
        begin
            nb = UW'(diff);
        end
    end

    assign new_idx    = wrap_add(tail, nb - UW'(1));
    assign range_mask = lo_mask(k_reg) & ~lo_mask(rd_ns);

    always_comb
    begin
        new_item             = '0;
        new_item.disposition = cmd.disp;
        case (cmd.emit_src)
            EM_DISP_ZERO:
            begin
                new_item.kind = KIND_DISP;
            end
            EM_DISP_IDX:
            begin
                new_item.kind = KIND_DISP;
                new_item.slot = SLOT_OUT_W'(idx_reg);
            end
            EM_DISP_NEW:
            begin
                new_item.kind = KIND_DISP;
                new_item.slot = SLOT_OUT_W'(new_idx);
            end
            EM_FLUSH:
            begin
                new_item.kind           = KIND_RELEASE;
                new_item.disposition    = DISP_ACCEPTED;
                new_item.slot           = SLOT_OUT_W'(front_reg);
                new_item.released_block = rd_blk;
                new_item.release_mask   = rd_map & range_mask;
            end
            EM_RUN:
            begin
                new_item.kind           = KIND_RELEASE;
                new_item.disposition    = DISP_ACCEPTED;
                new_item.slot           = SLOT_OUT_W'(idx_reg);
                new_item.released_block = rd_blk;
                new_item.release_mask   = mask_reg;
            end
            EM_FULL:
            begin
                new_item.kind            = KIND_RELEASE;
                new_item.disposition     = DISP_ACCEPTED;
                new_item.slot            = SLOT_OUT_W'(idx_reg);
                new_item.released_block  = rd_blk;
                new_item.release_mask    = want_reg;
                new_item.needs_recovery  = (pop_cnt_reg != '0);
                new_item.recovered_count = pop_cnt_reg;
            end
            default:
            begin
                new_item.kind = KIND_DISP;
            end
        endcase
    end

    // The pending item moves to the output register, marked last only on finish.
    always_comb
    begin
        out_load      = pend_reg;
        out_load.last = cmd.finish;
    end

    assign latch    = cmd.in_ready && frag.valid;
    assign out_free = !out_valid_reg || result.ready;

    assign stat.in_valid     = frag.valid;
    assign stat.f_invalid    = f_reg >= FRAG_IDX_W'(nf_reg);
    assign stat.search_end   = (rem_reg == '0);
    assign stat.match        = (rd_blk == b_reg);
    assign stat.stale        = newest_valid_reg && (b_reg <= newest_reg);
    assign stat.alloc_end    = (rem_reg == '0);
    assign stat.full         = (used_reg == UW'(RING_DEPTH));
    assign stat.dup          = rd_map[f_reg[4:0]];
    assign stat.at_front     = (idx_reg == front_reg);
    assign stat.run_bit      = (rd_ns < k_reg) && rd_map[rd_ns[4:0]];
    assign stat.ns_ge_k      = (rd_ns >= k_reg);
    assign stat.k_complete   = (rd_ns < k_reg) && (rd_cnt == k_reg);
    assign stat.front_is_idx = (front_reg == idx_reg);
    assign stat.pop_end      = (pop_idx_reg == 2'd3);
    assign stat.emit_ok      = !pend_valid_reg || out_free;
    assign stat.mask_nz      = (mask_reg != '0);
    assign stat.finish_ok    = out_free;

    assign frag.ready = cmd.in_ready;
    assign cfg.ready  = 1'b1;

    assign result.valid           = out_valid_reg;
    assign result.kind            = out_reg.kind;
    assign result.disposition     = out_reg.disposition;
    assign result.slot            = out_reg.slot;
    assign result.released_block  = out_reg.released_block;
    assign result.release_mask    = out_reg.release_mask;
    assign result.needs_recovery  = out_reg.needs_recovery;
    assign result.recovered_count = out_reg.recovered_count;
    assign result.last            = out_reg.last;

    always_ff @(posedge clk)
    begin
        if (cmd.alloc_step)
        begin
            blk_mem[wr_addr] <= alloc_blk_reg;
            map_mem[wr_addr] <= '0;
            cnt_mem[wr_addr] <= '0;
            ns_mem[wr_addr]  <= '0;
        end
        if (cmd.map_update)
        begin
            map_mem[wr_addr] <= rd_map | (MASK_W'(1) << f_reg[4:0]);
            cnt_mem[wr_addr] <= rd_cnt + CNT_W'(1);
        end
        if (cmd.run_step)
        begin
            ns_mem[wr_addr] <= rd_ns + CNT_W'(1);
        end
        if (cmd.set_ns_k)
        begin
            ns_mem[wr_addr] <= k_reg;
        end
    end

    // Item payload registers.
    always_ff @(posedge clk)
    begin
        if (latch)
        begin
            b_reg  <= frag.block_number;
            f_reg  <= frag.fragment_index;
            k_reg  <= k_eff;
            nf_reg <= nf_eff;
        end
        if (cmd.search_init)
        begin
            ptr_reg <= front_reg;
        end
        if (cmd.search_step)
        begin
            ptr_reg <= wrap_add(ptr_reg, UW'(1));
        end
        if (cmd.new_init)
        begin
            alloc_blk_reg <= b_reg - BLOCK_W'(nb) + BLOCK_W'(1);
        end
        if (cmd.alloc_step)
        begin
            alloc_blk_reg <= alloc_blk_reg + BLOCK_W'(1);
        end
        if (cmd.map_update)
        begin
            mask_reg <= '0;
        end
        if (cmd.run_step)
        begin
            mask_reg <= mask_reg | (MASK_W'(1) << rd_ns[4:0]);
        end
        if (cmd.pop_init)
        begin
            want_reg    <= range_mask;
            miss_reg    <= range_mask & ~rd_map;
            pop_cnt_reg <= '0;
        end
        if (cmd.pop_step)
        begin
            pop_cnt_reg <= pop_cnt_reg + CNT_W'($countones(miss_reg[7:0]));
            miss_reg    <= miss_reg >> 8;
        end
        if (cmd.emit)
        begin
            pend_reg <= new_item;
        end
        if ((cmd.emit && pend_valid_reg) || cmd.finish)
        begin
            out_reg <= out_load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_cfg_reg        <= RESET_DATA_FRAGMENTS;
            n_cfg_reg        <= RESET_TOTAL_FRAGMENTS;
            rem_reg          <= '0;
            idx_reg          <= '0;
            front_reg        <= '0;
            used_reg         <= '0;
            newest_reg       <= '0;
            newest_valid_reg <= 1'b0;
            pop_idx_reg      <= '0;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_DATA_FRAGMENTS:  k_cfg_reg <= cfg.data;
                    CFG_TOTAL_FRAGMENTS: n_cfg_reg <= cfg.data;
                    default:             ;
                endcase
            end
            if (cmd.search_init)
            begin
                rem_reg <= used_reg;
            end
            if (cmd.search_step)
            begin
                rem_reg <= rem_reg - UW'(1);
            end
            if (cmd.search_hit)
            begin
                idx_reg <= ptr_reg;
            end
            if (cmd.new_init)
            begin
                rem_reg          <= nb;
                newest_reg       <= b_reg;
                newest_valid_reg <= 1'b1;
            end
            if (cmd.alloc_step)
            begin
                rem_reg <= rem_reg - UW'(1);
                idx_reg <= tail;
                if (used_reg == UW'(RING_DEPTH))
                begin
                    front_reg <= wrap_add(front_reg, UW'(1));
                end
                else
                begin
                    used_reg <= used_reg + UW'(1);
                end
            end
            if (cmd.front_pop)
            begin
                front_reg <= wrap_add(front_reg, UW'(1));
                if (used_reg != '0)
                begin
                    used_reg <= used_reg - UW'(1);
                end
            end
            if (cmd.pop_init)
            begin
                pop_idx_reg <= '0;
            end
            if (cmd.pop_step)
            begin
                pop_idx_reg <= pop_idx_reg + 2'd1;
            end
            // Output register and pending item form a two-entry queue.
            if (cmd.emit)
            begin
                pend_valid_reg <= 1'b1;
                if (pend_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                end
                else if (result.ready)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
            else if (cmd.finish)
            begin
                pend_valid_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/fec_block_reorder_ring_core.sv @@
// Top level of the FEC block reorder ring: controller plus datapath.
//
//  channel  | dir | payload                                           | handshake
//  ---------+-----+---------------------------------------------------+-----------
//  frag     | in  | block_number, fragment_index                      | valid/ready
//  result   | out | kind, disposition, slot, released_block,          | valid/ready
//           |     | release_mask, needs_recovery, recovered_count,    |
//           |     | last                                              |
//  cfg      | in  | index, data (data_fragments, total_fragments)     | valid/ready
//
// One fragment is worked on at a time. The time an item takes grows with the open blocks
// walked by the slot search (one slot per cycle, at most RING_DEPTH), the slots opened for
// a newer block, the in-order run of fragments delivered (one per cycle) and the front
// blocks flushed ahead of a full release; the missing-fragment count is summed bytewise.
// Reset clears the ring pointers and the newest-block marker; the slot contents need no
// clearing since a slot is always written when it is opened. A stalled result channel
// holds the sequencer in place; the output register lets the next fragment be taken while
// the final result of the previous one still waits. The cfg port is always ready.
module fec_block_reorder_ring_core import frb_pkg::*; #(
    parameter int RING_DEPTH    = DEFAULT_RING_DEPTH,
    parameter int MAX_FRAGMENTS = DEFAULT_MAX_FRAGMENTS
) (
    input  logic         clk,
    input  logic         rst_n,
    frb_frag_if.sink     frag,
    frb_result_if.source result,
    frb_cfg_if.sink      cfg
);

    // Commands flow from the sequencer to the datapath, status flows back.
    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    frb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    frb_datapath #(
        .RING_DEPTH    (RING_DEPTH),
        .MAX_FRAGMENTS (MAX_FRAGMENTS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .frag   (frag),
        .result (result),
        .cfg    (cfg),
        .cmd    (cmd),
        .stat   (stat)
    );

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the FEC block reorder ring core.
module tb;
    import frb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING = DEFAULT_RING_DEPTH;
    localparam int FRAG_CAP = (DEFAULT_MAX_FRAGMENTS < 32) ? DEFAULT_MAX_FRAGMENTS : 32;
    localparam logic [BLOCK_W-1:0] BLOCK_MAX = '1;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 200;
    localparam int PHASE_ITEMS = 72;

    logic clk;
    logic rst_n;

    frb_frag_if   frag();
    frb_result_if result();
    frb_cfg_if    cfg();

    fec_block_reorder_ring_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frag   (frag.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    // Our own copy of the ring, kept in step with every accepted item.
    logic [BLOCK_W-1:0] ring_block [RING];
    logic [MASK_W-1:0]  ring_map   [RING];
    int unsigned        ring_count [RING];
    int unsigned        ring_nsend [RING];
    logic [3:0]         front_slot;
    int unsigned        open_blocks;
    logic [BLOCK_W-1:0] newest_seen;
    logic               newest_known;
    logic [CFG_W-1:0]   k_reg;
    logic [CFG_W-1:0]   n_reg;

    // Results that the core still owes us, oldest first.
    result_item_t owed_results[$];
    result_item_t pending[$];

    int  error_count;
    int  cycle_count = 0;
    bit  quiet_phase;
    bit  hold_request;
    bit  hold_done;

    // A directed row: the item, plus a typed disposition where one is obvious.
    typedef struct {
        logic [BLOCK_W-1:0]    blk;
        logic [FRAG_IDX_W-1:0] frg;
        bit                    typed;
        disp_t                 disp;
    } directed_row_t;

    directed_row_t directed_rows[$];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    function automatic logic [63:0] bit_span(input int unsigned lo, input int unsigned hi);
        logic [63:0] lo_bits;
        logic [63:0] hi_bits;
        if (lo >= hi)
        begin
            return 64'd0;
        end
        hi_bits = (64'd1 << hi) - 64'd1;
        lo_bits = (64'd1 << lo) - 64'd1;
        return hi_bits & ~lo_bits;
    endfunction

    function automatic int unsigned ones_in(input logic [63:0] v);
        int unsigned c;
        c = 0;
        for (int i = 0; i < 64; i++)
        begin
            c += v[i];
        end
        return c;
    endfunction

    function automatic void owe_item(input logic kind_v, input disp_t disp_v,
                                     input logic [3:0] slot_v, input logic [BLOCK_W-1:0] blk_v,
                                     input logic [63:0] mask_v, input logic rec_v,
                                     input int unsigned cnt_v);
        result_item_t r;
        r.kind            = kind_v;
        r.disposition     = disp_v;
        r.slot            = slot_v;
        r.released_block  = blk_v;
        r.release_mask    = mask_v[MASK_W-1:0];
        r.needs_recovery  = rec_v;
        r.recovered_count = CNT_W'(cnt_v);
        r.last            = 1'b0;
        pending.push_back(r);
    endfunction

    // Flushing the front block releases whatever data fragments it holds unsent.
    function automatic void flush_front_block(input int unsigned k);
        logic [3:0] s;
        s = front_slot;
        owe_item(KIND_RELEASE, DISP_ACCEPTED, s, ring_block[s],
                 {32'd0, ring_map[s]} & bit_span(ring_nsend[s], k), 1'b0, 0);
        front_slot = front_slot + 4'd1;
    endfunction

    // Works out every result item that one fragment causes and queues them.
    function automatic void predict_fragment(input logic [BLOCK_W-1:0] b,
                                             input logic [FRAG_IDX_W-1:0] f);
        int unsigned n_eff;
        int unsigned k;
        int unsigned span;
        int unsigned c;
        int unsigned ahead;
        int unsigned miss;
        logic [3:0]  idx;
        logic [3:0]  i;
        logic [63:0] run_bits;
        logic [63:0] want;
        bit          found;
        bit          done;
        n_eff = (n_reg == 0) ? 1 : n_reg;
        if (n_eff > FRAG_CAP) n_eff = FRAG_CAP;
        k = (k_reg == 0) ? 1 : k_reg;
        if (k > n_eff) k = n_eff;
        pending.delete();
        found = 1'b0;
        done  = 1'b0;
        idx   = '0;

        if (f >= n_eff)
        begin
            owe_item(KIND_DISP, DISP_INVALID, 4'd0, '0, 64'd0, 1'b0, 0);
            done = 1'b1;
        end
        if (!done)
        begin
            i = front_slot;
            for (c = open_blocks; c > 0 && !found; c--)
            begin
                if (ring_block[i] == b)
                begin
                    idx = i;
                    found = 1'b1;
                end
                i = i + 4'd1;
            end
        end
        if (!done && !found && newest_known && b <= newest_seen)
        begin
            owe_item(KIND_DISP, DISP_STALE, 4'd0, '0, 64'd0, 1'b0, 0);
            done = 1'b1;
        end
        if (!done)
        begin
            // Reserve the leading disposition; its fields are filled in below.
            owe_item(KIND_DISP, DISP_ACCEPTED, 4'd0, '0, 64'd0, 1'b0, 0);
            if (!found)
            begin
                // A jump past the newest block opens at most a ring's worth of blocks.
                span = 1;
                if (newest_known)
                begin
                    span = ((b - newest_seen) > RING) ? RING : int'(b - newest_seen);
                end
                newest_seen  = b;
                newest_known = 1'b1;
                for (int j = 0; j < span; j++)
                begin
                    if (open_blocks < RING)
                    begin
                        idx = front_slot + 4'(open_blocks);
                        open_blocks++;
                    end
                    else
                    begin
                        idx = front_slot;
                        flush_front_block(k);
                    end
                    ring_block[idx] = b + BLOCK_W'(j) + BLOCK_W'(1) - BLOCK_W'(span);
                    ring_map[idx]   = '0;
                    ring_count[idx] = 0;
                    ring_nsend[idx] = 0;
                end
            end
            pending[0].slot = idx;
            if (ring_map[idx][f])
            begin
                pending[0].disposition = DISP_DUPLICATE;
                done = 1'b1;
            end
        end
        if (!done)
        begin
            ring_map[idx][f] = 1'b1;
            ring_count[idx]  = (ring_count[idx] + 1) & 63;
            if (idx == front_slot)
            begin
                run_bits = '0;
                while (ring_nsend[idx] < k && ring_map[idx][ring_nsend[idx]])
                begin
                    run_bits[ring_nsend[idx]] = 1'b1;
                    ring_nsend[idx]++;
                end
                if (run_bits != 0)
                begin
                    owe_item(KIND_RELEASE, DISP_ACCEPTED, idx, ring_block[idx], run_bits, 1'b0, 0);
                end
                if (ring_nsend[idx] >= k)
                begin
                    front_slot = front_slot + 4'd1;
                    if (open_blocks > 0) open_blocks--;
                    done = 1'b1;
                end
            end
        end
        if (!done && ring_nsend[idx] < k && ring_count[idx] == k)
        begin
            // K fragments are in: older blocks are flushed and this one goes out whole.
            ahead = 4'(idx - front_slot);
            while (ahead > 0)
            begin
                flush_front_block(k);
                if (open_blocks > 0) open_blocks--;
                ahead--;
            end
            want = bit_span(ring_nsend[idx], k);
            miss = ones_in(want & ~{32'd0, ring_map[idx]});
            owe_item(KIND_RELEASE, DISP_ACCEPTED, idx, ring_block[idx], want, miss != 0, miss);
            ring_nsend[idx] = k;
            front_slot = front_slot + 4'd1;
            if (open_blocks > 0) open_blocks--;
        end
        pending[pending.size()-1].last = 1'b1;
        foreach (pending[p])
        begin
            owed_results.push_back(pending[p]);
        end
    endfunction

    // Result checker: every accepted item is matched against the oldest owed one.
    always @(posedge clk)
    begin
        result_item_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (owed_results.size() == 0)
            begin
                report_mismatch("unexpected item", {63'd0, result.kind}, 64'd0);
            end
            else
            begin
                want = owed_results.pop_front();
                if (result.kind !== want.kind)
                    report_mismatch("kind", result.kind, want.kind);
                if (result.disposition !== want.disposition)
                    report_mismatch("disposition", result.disposition, want.disposition);
                if (result.slot !== want.slot)
                    report_mismatch("slot", result.slot, want.slot);
                if (result.released_block !== want.released_block)
                    report_mismatch("released_block", result.released_block,
                                    want.released_block);
                if (result.release_mask !== want.release_mask)
                    report_mismatch("release_mask", result.release_mask, want.release_mask);
                if (result.needs_recovery !== want.needs_recovery)
                    report_mismatch("needs_recovery", result.needs_recovery,
                                    want.needs_recovery);
                if (result.recovered_count !== want.recovered_count)
                    report_mismatch("recovered_count", result.recovered_count,
                                    want.recovered_count);
                if (result.last !== want.last)
                    report_mismatch("last", result.last, want.last);
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off on request, none when quiet.
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        result.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done && hold_left == 0)
            begin
                hold_left = 600;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                if (hold_left == 0) hold_done = 1'b1;
                result.ready = 1'b0;
            end
            else if (quiet_phase)
            begin
                result.ready = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result.ready = 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                result.ready = 1'b0;
            end
            else
            begin
                result.ready = 1'b1;
            end
        end
    end

    // Offers one item and holds it until the core takes it; valid stays high after.
    task automatic send_fragment(input logic [BLOCK_W-1:0] b, input logic [FRAG_IDX_W-1:0] f,
                                 input bit typed, input disp_t typed_disp);
        int first;
        @(negedge clk);
        frag.valid = 1'b1;
        frag.block_number = b;
        frag.fragment_index = f;
        do
        begin
            @(posedge clk);
        end
        while (!frag.ready);
        first = owed_results.size();
        predict_fragment(b, f);
        if (typed)
        begin
            owed_results[first].disposition = typed_disp;
        end
    endtask

    task automatic sender_gap();
        int len;
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            len = $urandom_range(1, 17);
            @(negedge clk);
            frag.valid = 1'b0;
            repeat (len - 1) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        frag.valid = 1'b0;
        while (owed_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register writes only happen once the core has gone idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg.valid = 1'b1;
        cfg.index = index;
        cfg.data  = value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg.ready);
        if (index == CFG_DATA_FRAGMENTS) k_reg = value;
        else if (index == CFG_TOTAL_FRAGMENTS) n_reg = value;
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    function automatic void add_row(input logic [BLOCK_W-1:0] b, input logic [FRAG_IDX_W-1:0] f,
                                    input bit typed, input disp_t disp);
        directed_row_t r;
        r.blk = b;
        r.frg = f;
        r.typed = typed;
        r.disp = disp;
        directed_rows.push_back(r);
    endfunction

    // Random fragments mostly land on recent blocks so the ring fills, runs and
    // releases; a share are stale, invalid, or jump well ahead.
    task automatic random_fragments(input int count, input logic [BLOCK_W-1:0] floor_blk);
        int unsigned n_eff;
        int sel;
        logic [BLOCK_W-1:0] b;
        logic [FRAG_IDX_W-1:0] f;
        for (int t = 0; t < count; t++)
        begin
            n_eff = (n_reg == 0) ? 1 : ((n_reg > FRAG_CAP) ? FRAG_CAP : n_reg);
            sel = $urandom_range(0, 99);
            if (!newest_known || newest_seen < floor_blk)
                b = floor_blk;
            else if (sel < 8)
                b = newest_seen + BLOCK_W'($urandom_range(2, 40));
            else if (sel < 14 && newest_seen > 60)
                b = newest_seen - BLOCK_W'($urandom_range(17, 60));
            else if (sel < 30)
                b = newest_seen + BLOCK_W'($urandom_range(0, 1));
            else
                b = newest_seen - BLOCK_W'($urandom_range(0, 5));
            if (b == BLOCK_MAX || (newest_known && newest_seen == BLOCK_MAX && b < 10))
                b = newest_seen;
            if ($urandom_range(0, 19) == 0)
                f = FRAG_IDX_W'($urandom_range(n_eff, 255));
            else
                f = FRAG_IDX_W'($urandom_range(0, n_eff - 1));
            send_fragment(b, f, 1'b0, DISP_ACCEPTED);
            sender_gap();
        end
    endtask

    initial
    begin
        logic [BLOCK_W-1:0] base;
        error_count = 0;
        quiet_phase = 1'b0;
        hold_request = 1'b0;
        hold_done = 1'b0;
        frag.valid = 1'b0;
        frag.block_number = '0;
        frag.fragment_index = '0;
        cfg.valid = 1'b0;
        cfg.index = CFG_DATA_FRAGMENTS;
        cfg.data = '0;
        for (int s = 0; s < RING; s++)
        begin
            ring_block[s] = '0;
            ring_map[s] = '0;
            ring_count[s] = 0;
            ring_nsend[s] = 0;
        end
        front_slot = '0;
        open_blocks = 0;
        newest_seen = '0;
        newest_known = 1'b0;
        k_reg = RESET_DATA_FRAGMENTS;
        n_reg = RESET_TOTAL_FRAGMENTS;

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset setting, K of 8 and N of 12.
        add_row(56'd5, 8'd12, 1'b1, DISP_INVALID);      // index just past N
        add_row(56'd5, 8'd255, 1'b1, DISP_INVALID);     // largest index
        add_row(56'd5, 8'd0, 1'b1, DISP_ACCEPTED);      // first block, in-order start
        add_row(56'd5, 8'd0, 1'b1, DISP_DUPLICATE);     // same fragment again
        add_row(56'd3, 8'd1, 1'b1, DISP_STALE);         // older than the newest block
        add_row(56'd5, 8'd2, 1'b0, DISP_ACCEPTED);
        add_row(56'd5, 8'd1, 1'b0, DISP_ACCEPTED);      // fills the gap, longer run
        add_row(56'd6, 8'd11, 1'b0, DISP_ACCEPTED);     // parity fragment
        add_row(56'd30, 8'd3, 1'b0, DISP_ACCEPTED);     // gap jump overflows the ring
        add_row(56'd30, 8'd4, 1'b0, DISP_ACCEPTED);
        add_row(56'd30, 8'd8, 1'b0, DISP_ACCEPTED);
        add_row(56'd30, 8'd9, 1'b0, DISP_ACCEPTED);
        add_row(56'd30, 8'd10, 1'b0, DISP_ACCEPTED);
        add_row(56'd30, 8'd11, 1'b0, DISP_ACCEPTED);
        add_row(56'd30, 8'd5, 1'b0, DISP_ACCEPTED);
        add_row(56'd30, 8'd6, 1'b0, DISP_ACCEPTED);     // K reached: full release, recovery
        add_row(56'd31, 8'd0, 1'b0, DISP_ACCEPTED);
        add_row(56'd29, 8'd0, 1'b0, DISP_ACCEPTED);     // flushed already, so stale
        foreach (directed_rows[r])
        begin
            send_fragment(directed_rows[r].blk, directed_rows[r].frg,
                          directed_rows[r].typed, directed_rows[r].disp);
            sender_gap();
        end
        drain_results();

        // Random phases over several settings; the ring is never cleared between them.
        base = {1'b0, 23'($urandom), 32'($urandom)} | 56'd1000;
        random_fragments(PHASE_ITEMS, base);
        drain_results();

        write_register(CFG_DATA_FRAGMENTS, 6'd1);
        write_register(CFG_TOTAL_FRAGMENTS, 6'd1);
        hold_request = 1'b1;   // long receiver hold-off while fragments keep coming
        random_fragments(PHASE_ITEMS, base);
        drain_results();

        write_register(CFG_TOTAL_FRAGMENTS, 6'd32);
        write_register(CFG_DATA_FRAGMENTS, 6'd32);
        random_fragments(PHASE_ITEMS, base);
        drain_results();

        write_register(CFG_DATA_FRAGMENTS, 6'd0);     // zero acts as one
        write_register(CFG_TOTAL_FRAGMENTS, 6'd0);
        random_fragments(PHASE_ITEMS / 2, base);
        drain_results();

        write_register(CFG_DATA_FRAGMENTS, 6'd63);    // both saturate
        write_register(CFG_TOTAL_FRAGMENTS, 6'd63);
        random_fragments(PHASE_ITEMS / 2, base);
        drain_results();

        write_register(CFG_DATA_FRAGMENTS, 6'd4);
        write_register(CFG_TOTAL_FRAGMENTS, 6'd6);
        random_fragments(PHASE_ITEMS, base);
        drain_results();

        // Final stretch without idling, climbing to the top of the block range.
        write_register(CFG_DATA_FRAGMENTS, 6'd3);
        write_register(CFG_TOTAL_FRAGMENTS, 6'd16);
        quiet_phase = 1'b1;
        random_fragments(PHASE_ITEMS, BLOCK_MAX - 56'd120);
        send_fragment(BLOCK_MAX, 8'd0, 1'b0, DISP_ACCEPTED);
        drain_results();

        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/frb_pkg.sv
rtl/frb_if.sv
rtl/frb_ctrl.sv
rtl/frb_datapath.sv
rtl/fec_block_reorder_ring_core.sv
bench/tb.sv
